// ===== hw/rtl/pthc_pkg.sv =====
`timescale 1ns / 1ps
// pthc_pkg: shared types, constants and register indexes for the sensor
// compensation pipeline. No dependencies.
package pthc_pkg;

    localparam int DIV_W        = 64;
    localparam int FRONT_STAGES = 15;
    localparam int BACK_STAGES  = 6;

    localparam logic [7:0] REG_TEMP_COEFFS   = 8'd0;
    localparam logic [7:0] REG_PRESS_LOW     = 8'd1;
    localparam logic [7:0] REG_PRESS_HIGH    = 8'd2;
    localparam logic [7:0] REG_PRESS_LAST    = 8'd3;
    localparam logic [7:0] REG_HUM_COEFFS    = 8'd4;

    localparam logic [33:0] TF_PRESS_OFFSET = 34'd128000;
    localparam logic [63:0] PRESS_RAW_BASE  = 64'd1048576;
    localparam logic [11:0] PRESS_SCALE     = 12'd3125;
    localparam logic [31:0] TF_HUM_OFFSET   = 32'd76800;
    localparam logic signed [31:0] HUM_CLAMP = 32'sd419430400;
    localparam logic [31:0] HUM_ROUND       = 32'd16384;
    localparam logic [31:0] HUM_BIAS        = 32'd2097152;
    localparam logic [31:0] HUM_W_ROUND     = 32'd8192;
    localparam logic [31:0] HUM_Z_BIAS      = 32'd32768;
    localparam logic [31:0] TEMP_ROUND      = 32'd128;
    localparam logic [63:0] PRESS_V1_BIAS   = 64'h0000_8000_0000_0000;
    localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
    localparam logic signed [31:0] TEMP_MAX = 32'sd32767;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_low;
        logic [63:0] press_high;
        logic [15:0] press_last;
        logic [63:0] hum;
    } t_cfg;

    typedef struct packed {
        logic [15:0]      tc;
        logic [16:0]      hum;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_front_out;

    typedef struct packed {
        logic [15:0]      tc;
        logic [16:0]      hum;
        logic [DIV_W-1:0] quo;
        logic             neg;
        logic             dz;
    } t_div_out;

    typedef struct packed {
        logic [15:0] tc;
        logic [31:0] pres;
        logic        pvalid;
        logic [16:0] hum;
    } t_res;

endpackage

// ===== hw/rtl/pthc_front.sv =====
`timescale 1ns / 1ps
// pthc_front: fine temperature, temperature, humidity and the pressure
// dividend/divisor, 15 register stages. Depends on pthc_pkg.
module pthc_front
    import pthc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [19:0] i_raw_p,
    input  logic [19:0] i_raw_t,
    input  logic [15:0] i_raw_h,
    input  t_cfg        i_cfg,
    output logic        o_vld,
    output t_front_out  o_data
);

    logic [15:0] t1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
    logic [15:0] p1;
    logic [7:0] h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0] h6;

    assign t1 = i_cfg.temp[15:0];
    assign t2 = i_cfg.temp[31:16];
    assign t3 = i_cfg.temp[47:32];
    assign p1 = i_cfg.press_low[15:0];
    assign p2 = i_cfg.press_low[31:16];
    assign p3 = i_cfg.press_low[47:32];
    assign p4 = i_cfg.press_low[63:48];
    assign p5 = i_cfg.press_high[15:0];
    assign p6 = i_cfg.press_high[31:16];
    assign h1 = i_cfg.hum[7:0];
    assign h2 = i_cfg.hum[23:8];
    assign h3 = i_cfg.hum[31:24];
    assign h4 = i_cfg.hum[43:32];
    assign h5 = i_cfg.hum[55:44];
    assign h6 = i_cfg.hum[63:56];

    logic [FRONT_STAGES-1:0] r_vld;

    logic [31:0] r_s1_a, r_s1_b, n_s1_a, n_s1_b;
    logic [19:0] r_s1_ap, r_s2_ap, r_s3_ap, r_s4_ap;
    logic [15:0] r_s1_ah, r_s2_ah, r_s3_ah, r_s4_ah, r_s5_ah, r_s6_ah;
    logic [31:0] r_s2_m1, r_s2_m2, n_s2_m1, n_s2_m2;
    logic [31:0] r_s3_var1, r_s3_m3, n_s3_var1, n_s3_m3;
    logic [31:0] r_s4_tf, n_s4_tf;
    logic [15:0] r_s5_tc, n_s5_tc;
    logic signed [33:0] r_s5_v1, n_s5_v1;
    logic [31:0] r_s5_hv, n_s5_hv;
    logic [63:0] r_s5_pp0, n_s5_pp0;
    logic [15:0] r_s6_tc, r_s7_tc, r_s8_tc, r_s9_tc, r_s10_tc, r_s11_tc, r_s12_tc;
    logic [15:0] r_s13_tc, r_s14_tc, r_s15_tc;
    logic [63:0] r_s6_pp0, r_s7_pp0, r_s8_pp0;
    logic [63:0] r_s6_sq, r_s6_v1p5, r_s6_v1p2, n_s6_sq, n_s6_v1p5, n_s6_v1p2;
    logic [31:0] r_s6_ph5, r_s6_ph6, r_s6_ph3, n_s6_ph5, n_s6_ph6, n_s6_ph3;
    logic [63:0] r_s7_sqp6, r_s7_sqp3, r_s7_v1p5, r_s7_v1p2, n_s7_sqp6, n_s7_sqp3;
    logic [31:0] r_s7_x, r_s7_y, r_s7_z, n_s7_x, n_s7_y, n_s7_z;
    logic [63:0] r_s8_v2, r_s8_v1b, n_s8_v2, n_s8_v1b;
    logic [31:0] r_s8_yz, n_s8_yz, r_s8_x, r_s9_x, r_s10_x, r_s11_x;
    logic [63:0] r_s9_v1s, r_s9_nb, n_s9_v1s, n_s9_nb;
    logic [31:0] r_s9_w, n_s9_w;
    logic [63:0] r_s10_v1c, r_s10_nn, n_s10_v1c, n_s10_nn;
    logic [31:0] r_s10_wh2, n_s10_wh2;
    logic [63:0] r_s11_d, n_s11_d, r_s11_nn, r_s12_d, r_s12_nn, r_s13_d, r_s13_nn;
    logic [63:0] r_s14_d, r_s14_nn, r_s15_d, r_s15_nn;
    logic [31:0] r_s11_w2, n_s11_w2;
    logic [31:0] r_s12_xw, n_s12_xw, r_s13_xw, r_s14_xw;
    logic [31:0] r_s13_ss, n_s13_ss;
    logic [31:0] r_s14_t, n_s14_t;
    logic [16:0] r_s15_hum, n_s15_hum;

    logic signed [47:0] w_m1;
    logic signed [31:0] w_m2s;
    logic signed [47:0] w_m3;
    logic [31:0] w_t5;
    logic signed [31:0] w_tcs;
    logic signed [67:0] w_sq;
    logic signed [49:0] w_v1p5, w_v1p2;
    logic signed [43:0] w_ph5;
    logic signed [39:0] w_ph6;
    logic signed [40:0] w_ph3;
    logic signed [79:0] w_sqp6, w_sqp3;
    logic [31:0] w_xs;
    logic [79:0] w_v1c;
    logic [75:0] w_nn;
    logic signed [47:0] w_wh2;
    logic signed [31:0] w_s;
    logic signed [31:0] w_ssa;
    logic signed [40:0] w_t;
    logic signed [31:0] w_hs;

    always_comb begin
        n_s1_a = {15'd0, i_raw_t[19:3]} - {15'd0, t1, 1'b0};
        n_s1_b = {16'd0, i_raw_t[19:4]} - {16'd0, t1};

        w_m1    = $signed(r_s1_a) * t2;
        n_s2_m1 = w_m1[31:0];
        n_s2_m2 = r_s1_b * r_s1_b;

        n_s3_var1 = $signed(r_s2_m1) >>> 11;
        w_m2s     = $signed(r_s2_m2) >>> 12;
        w_m3      = w_m2s * t3;
        n_s3_m3   = w_m3[31:0];

        n_s4_tf = r_s3_var1 + 32'($signed(r_s3_m3) >>> 14);

        w_t5  = r_s4_tf * 32'd5 + TEMP_ROUND;
        w_tcs = $signed(w_t5) >>> 8;
        if (w_tcs < TEMP_MIN) begin
            n_s5_tc = 16'h8000;
        end else if (w_tcs > TEMP_MAX) begin
            n_s5_tc = 16'h7fff;
        end else begin
            n_s5_tc = w_tcs[15:0];
        end
        n_s5_v1  = $signed({{2{r_s4_tf[31]}}, r_s4_tf} - TF_PRESS_OFFSET);
        n_s5_hv  = r_s4_tf - TF_HUM_OFFSET;
        n_s5_pp0 = (PRESS_RAW_BASE - {44'd0, r_s4_ap}) << 31;

        w_sq      = r_s5_v1 * r_s5_v1;
        n_s6_sq   = w_sq[63:0];
        w_v1p5    = r_s5_v1 * p5;
        n_s6_v1p5 = {{14{w_v1p5[49]}}, w_v1p5};
        w_v1p2    = r_s5_v1 * p2;
        n_s6_v1p2 = {{14{w_v1p2[49]}}, w_v1p2};
        w_ph5     = $signed(r_s5_hv) * h5;
        n_s6_ph5  = w_ph5[31:0];
        w_ph6     = $signed(r_s5_hv) * h6;
        n_s6_ph6  = w_ph6[31:0];
        w_ph3     = $signed(r_s5_hv) * $signed({1'b0, h3});
        n_s6_ph3  = w_ph3[31:0];

        w_sqp6    = $signed(r_s6_sq) * p6;
        n_s7_sqp6 = w_sqp6[63:0];
        w_sqp3    = $signed(r_s6_sq) * p3;
        n_s7_sqp3 = w_sqp3[63:0];
        w_xs   = {2'd0, r_s6_ah, 14'd0} - {h4, 20'd0} - r_s6_ph5 + HUM_ROUND;
        n_s7_x = $signed(w_xs) >>> 15;
        n_s7_y = $signed(r_s6_ph6) >>> 10;
        n_s7_z = 32'($signed(r_s6_ph3) >>> 11) + HUM_Z_BIAS;

        n_s8_v2  = r_s7_sqp6 + (r_s7_v1p5 << 17) + {{13{p4[15]}}, p4, 35'd0};
        n_s8_v1b = 64'($signed(r_s7_sqp3) >>> 8) + (r_s7_v1p2 << 12);
        n_s8_yz  = r_s7_y * r_s7_z;

        n_s9_v1s = PRESS_V1_BIAS + r_s8_v1b;
        n_s9_nb  = r_s8_pp0 - r_s8_v2;
        n_s9_w   = 32'($signed(r_s8_yz) >>> 10) + HUM_BIAS;

        w_v1c     = r_s9_v1s * p1;
        n_s10_v1c = w_v1c[63:0];
        w_nn      = r_s9_nb * PRESS_SCALE;
        n_s10_nn  = w_nn[63:0];
        w_wh2     = $signed(r_s9_w) * h2;
        n_s10_wh2 = w_wh2[31:0];

        n_s11_d  = $signed(r_s10_v1c) >>> 33;
        n_s11_w2 = $signed(r_s10_wh2 + HUM_W_ROUND) >>> 14;

        n_s12_xw = r_s11_x * r_s11_w2;

        w_s      = $signed(r_s12_xw) >>> 15;
        n_s13_ss = w_s * w_s;

        w_ssa   = $signed(r_s13_ss) >>> 7;
        w_t     = w_ssa * $signed({1'b0, h1});
        n_s14_t = w_t[31:0];

        w_hs = $signed(r_s14_xw - 32'($signed(r_s14_t) >>> 4));
        if (w_hs < 0) begin
            n_s15_hum = 17'd0;
        end else if (w_hs > HUM_CLAMP) begin
            n_s15_hum = HUM_CLAMP[28:12];
        end else begin
            n_s15_hum = w_hs[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a <= n_s1_a;  r_s1_b <= n_s1_b;  r_s1_ap <= i_raw_p;  r_s1_ah <= i_raw_h;
            r_s2_m1 <= n_s2_m1;  r_s2_m2 <= n_s2_m2;  r_s2_ap <= r_s1_ap;  r_s2_ah <= r_s1_ah;
            r_s3_var1 <= n_s3_var1;  r_s3_m3 <= n_s3_m3;
            r_s3_ap <= r_s2_ap;  r_s3_ah <= r_s2_ah;
            r_s4_tf <= n_s4_tf;  r_s4_ap <= r_s3_ap;  r_s4_ah <= r_s3_ah;
            r_s5_tc <= n_s5_tc;  r_s5_v1 <= n_s5_v1;  r_s5_hv <= n_s5_hv;
            r_s5_pp0 <= n_s5_pp0;  r_s5_ah <= r_s4_ah;
            r_s6_sq <= n_s6_sq;  r_s6_v1p5 <= n_s6_v1p5;  r_s6_v1p2 <= n_s6_v1p2;
            r_s6_ph5 <= n_s6_ph5;  r_s6_ph6 <= n_s6_ph6;  r_s6_ph3 <= n_s6_ph3;
            r_s6_tc <= r_s5_tc;  r_s6_pp0 <= r_s5_pp0;  r_s6_ah <= r_s5_ah;
            r_s7_sqp6 <= n_s7_sqp6;  r_s7_sqp3 <= n_s7_sqp3;
            r_s7_v1p5 <= r_s6_v1p5;  r_s7_v1p2 <= r_s6_v1p2;
            r_s7_x <= n_s7_x;  r_s7_y <= n_s7_y;  r_s7_z <= n_s7_z;
            r_s7_tc <= r_s6_tc;  r_s7_pp0 <= r_s6_pp0;
            r_s8_v2 <= n_s8_v2;  r_s8_v1b <= n_s8_v1b;  r_s8_yz <= n_s8_yz;
            r_s8_x <= r_s7_x;  r_s8_tc <= r_s7_tc;  r_s8_pp0 <= r_s7_pp0;
            r_s9_v1s <= n_s9_v1s;  r_s9_nb <= n_s9_nb;  r_s9_w <= n_s9_w;
            r_s9_x <= r_s8_x;  r_s9_tc <= r_s8_tc;
            r_s10_v1c <= n_s10_v1c;  r_s10_nn <= n_s10_nn;  r_s10_wh2 <= n_s10_wh2;
            r_s10_x <= r_s9_x;  r_s10_tc <= r_s9_tc;
            r_s11_d <= n_s11_d;  r_s11_w2 <= n_s11_w2;  r_s11_nn <= r_s10_nn;
            r_s11_x <= r_s10_x;  r_s11_tc <= r_s10_tc;
            r_s12_xw <= n_s12_xw;  r_s12_d <= r_s11_d;  r_s12_nn <= r_s11_nn;
            r_s12_tc <= r_s11_tc;
            r_s13_ss <= n_s13_ss;  r_s13_xw <= r_s12_xw;  r_s13_d <= r_s12_d;
            r_s13_nn <= r_s12_nn;  r_s13_tc <= r_s12_tc;
            r_s14_t <= n_s14_t;  r_s14_xw <= r_s13_xw;  r_s14_d <= r_s13_d;
            r_s14_nn <= r_s13_nn;  r_s14_tc <= r_s13_tc;
            r_s15_hum <= n_s15_hum;  r_s15_d <= r_s14_d;  r_s15_nn <= r_s14_nn;
            r_s15_tc <= r_s14_tc;
        end
    end

    assign o_vld       = r_vld[FRONT_STAGES-1];
    assign o_data.tc   = r_s15_tc;
    assign o_data.hum  = r_s15_hum;
    assign o_data.num  = r_s15_nn;
    assign o_data.den  = r_s15_d;

endmodule

// ===== hw/rtl/pthc_div.sv =====
`timescale 1ns / 1ps
// pthc_div: pipelined signed 64-bit restoring divider, one quotient bit per
// stage, with side payload carried along. Depends on pthc_pkg.
module pthc_div
    import pthc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_front_out i_data,
    output logic       o_vld,
    output t_div_out   o_data
);

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dq;
        logic [DIV_W-1:0] den;
        logic             neg;
        logic             dz;
        logic [15:0]      tc;
        logic [16:0]      hum;
    } t_div_stage;

    t_div_stage r_st [0:DIV_W];
    logic [DIV_W:0] r_vld;
    t_div_stage n_st0;

    always_comb begin
        n_st0.rem = '0;
        n_st0.dq  = i_data.num[DIV_W-1] ? -i_data.num : i_data.num;
        n_st0.den = i_data.den[DIV_W-1] ? -i_data.den : i_data.den;
        n_st0.neg = i_data.num[DIV_W-1] ^ i_data.den[DIV_W-1];
        n_st0.dz  = (i_data.den == '0);
        n_st0.tc  = i_data.tc;
        n_st0.hum = i_data.hum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_W-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W:0] w_trial;
        logic           w_ge;
        t_div_stage     n_nxt;

        always_comb begin
            w_trial   = {r_st[k].rem, r_st[k].dq[DIV_W-1]};
            w_ge      = (w_trial >= {1'b0, r_st[k].den});
            n_nxt     = r_st[k];
            n_nxt.rem = w_ge ? DIV_W'(w_trial - {1'b0, r_st[k].den})
                             : w_trial[DIV_W-1:0];
            n_nxt.dq  = {r_st[k].dq[DIV_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_nxt;
            end
        end
    end

    assign o_vld      = r_vld[DIV_W];
    assign o_data.tc  = r_st[DIV_W].tc;
    assign o_data.hum = r_st[DIV_W].hum;
    assign o_data.quo = r_st[DIV_W].dq;
    assign o_data.neg = r_st[DIV_W].neg;
    assign o_data.dz  = r_st[DIV_W].dz;

endmodule

// ===== hw/rtl/pthc_back.sv =====
`timescale 1ns / 1ps
// pthc_back: pressure correction after the divide and final saturation,
// 6 register stages. Depends on pthc_pkg.
module pthc_back
    import pthc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_vld,
    input  t_div_out i_data,
    input  t_cfg     i_cfg,
    output logic     o_vld,
    output t_res     o_res
);

    logic signed [15:0] p7, p8, p9;
    assign p7 = i_cfg.press_high[47:32];
    assign p8 = i_cfg.press_high[63:48];
    assign p9 = i_cfg.press_last;

    logic [BACK_STAGES-1:0] r_vld;

    logic [15:0] r_s1_tc, r_s2_tc, r_s3_tc, r_s4_tc, r_s5_tc;
    logic [16:0] r_s1_hum, r_s2_hum, r_s3_hum, r_s4_hum, r_s5_hum;
    logic        r_s1_dz, r_s2_dz, r_s3_dz, r_s4_dz, r_s5_dz;
    logic [63:0] r_s1_pp, n_s1_pp, r_s2_pp, r_s3_pp, r_s4_pp;
    logic [63:0] r_s2_ll, n_s2_ll;
    logic [31:0] r_s2_lh, n_s2_lh;
    logic [63:0] r_s2_p8pp, n_s2_p8pp, r_s3_p8pp, r_s4_p8pp;
    logic [63:0] r_s3_qsq, n_s3_qsq;
    logic [63:0] r_s4_w1, n_s4_w1;
    logic [63:0] r_s5_sum, n_s5_sum;
    t_res        r_s6, n_s6;

    logic [63:0] w_qq;
    logic signed [79:0] w_p8pp, w_w1;
    logic [63:0] w_f;

    always_comb begin
        n_s1_pp = i_data.neg ? -i_data.quo : i_data.quo;

        w_qq      = $signed(r_s1_pp) >>> 13;
        n_s2_ll   = {32'd0, w_qq[31:0]} * {32'd0, w_qq[31:0]};
        n_s2_lh   = w_qq[31:0] * w_qq[63:32];
        w_p8pp    = $signed(r_s1_pp) * p8;
        n_s2_p8pp = w_p8pp[63:0];

        n_s3_qsq = r_s2_ll + {r_s2_lh[30:0], 1'b0, 32'd0};

        w_w1    = $signed(r_s3_qsq) * p9;
        n_s4_w1 = w_w1[63:0];

        n_s5_sum = r_s4_pp + 64'($signed(r_s4_w1) >>> 25)
                 + 64'($signed(r_s4_p8pp) >>> 19);

        w_f = 64'($signed(r_s5_sum) >>> 8) + {{44{p7[15]}}, p7, 4'd0};
        n_s6.tc     = r_s5_tc;
        n_s6.hum    = r_s5_hum;
        n_s6.pvalid = !r_s5_dz;
        if (r_s5_dz || w_f[63]) begin
            n_s6.pres = 32'd0;
        end else if (w_f[63:32] != 32'd0) begin
            n_s6.pres = 32'hffff_ffff;
        end else begin
            n_s6.pres = w_f[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[BACK_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pp <= n_s1_pp;  r_s1_tc <= i_data.tc;  r_s1_hum <= i_data.hum;
            r_s1_dz <= i_data.dz;
            r_s2_ll <= n_s2_ll;  r_s2_lh <= n_s2_lh;  r_s2_p8pp <= n_s2_p8pp;
            r_s2_pp <= r_s1_pp;  r_s2_tc <= r_s1_tc;  r_s2_hum <= r_s1_hum;
            r_s2_dz <= r_s1_dz;
            r_s3_qsq <= n_s3_qsq;  r_s3_p8pp <= r_s2_p8pp;  r_s3_pp <= r_s2_pp;
            r_s3_tc <= r_s2_tc;  r_s3_hum <= r_s2_hum;  r_s3_dz <= r_s2_dz;
            r_s4_w1 <= n_s4_w1;  r_s4_p8pp <= r_s3_p8pp;  r_s4_pp <= r_s3_pp;
            r_s4_tc <= r_s3_tc;  r_s4_hum <= r_s3_hum;  r_s4_dz <= r_s3_dz;
            r_s5_sum <= n_s5_sum;  r_s5_tc <= r_s4_tc;  r_s5_hum <= r_s4_hum;
            r_s5_dz <= r_s4_dz;
            r_s6 <= n_s6;
        end
    end

    assign o_vld = r_vld[BACK_STAGES-1];
    assign o_res = r_s6;

endmodule

// ===== hw/rtl/pth_sensor_compensation_top.sv =====
`timescale 1ns / 1ps
// pth_sensor_compensation_top: stream wrapper, calibration registers and
// output skid stage. Depends on pthc_pkg, pthc_front, pthc_div, pthc_back.
//
// Takes one raw pressure/temperature/humidity sample per cycle and returns
// one compensated result per sample, in order. Throughput is one transaction
// per clock while the skid stage is empty. Stages: 15 front, 65 divider
// (operand stage, then one quotient bit each), 6 pressure correction, output
// register. The user must write calibration words through the cfg port only
// while no sample is in flight (not enforced). No clearing pass after reset.
module pth_sensor_compensation_top
    import pthc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // temperature_centi[15:0], pressure_q24_8[47:16], humidity_q7_10[64:48]
    output logic [71:0] o_m_axis_tdata,
    // pressure_valid[0]
    output logic [0:0]  o_m_axis_tuser
);

    t_cfg r_cfg;
    logic w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TEMP_COEFFS: r_cfg.temp       <= i_cfg_wdata[47:0];
                REG_PRESS_LOW:   r_cfg.press_low  <= i_cfg_wdata;
                REG_PRESS_HIGH:  r_cfg.press_high <= i_cfg_wdata;
                REG_PRESS_LAST:  r_cfg.press_last <= i_cfg_wdata[15:0];
                REG_HUM_COEFFS:  r_cfg.hum        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic       w_f_vld, w_d_vld, w_b_vld;
    t_front_out w_f_data;
    t_div_out   w_d_data;
    t_res       w_b_res;

    pthc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_raw_p (i_s_axis_tdata[19:0]),
        .i_raw_t (i_s_axis_tdata[39:20]),
        .i_raw_h (i_s_axis_tdata[55:40]),
        .i_cfg   (r_cfg),
        .o_vld   (w_f_vld),
        .o_data  (w_f_data)
    );

    pthc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_data  (w_f_data),
        .o_vld   (w_d_vld),
        .o_data  (w_d_data)
    );

    pthc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_data  (w_d_data),
        .i_cfg   (r_cfg),
        .o_vld   (w_b_vld),
        .o_res   (w_b_res)
    );

    logic r_out_vld, r_skid_vld;
    t_res r_out, r_skid;

    assign w_en = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_b_vld;
            end
        end else if (w_en && w_b_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : w_b_res;
        end else if (w_en && w_b_vld) begin
            r_skid <= w_b_res;
        end
    end

    assign o_s_axis_tready   = w_en;
    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = {7'd0, r_out.hum, r_out.pres, r_out.tc};
    assign o_m_axis_tuser[0] = r_out.pvalid;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage full while output register empty");

    a_stall_only_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !$past(r_skid_vld)) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid filled without an output hold");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[47:16] == 32'd0))
        else $error("invalid pressure not zero");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[64:48] <= 17'd102400))
        else $error("humidity out of range");
`endif

endmodule
